// File: design/htp_pkg.sv
// Shared types and constants for the header template tag parser.
// Holds the input and result transaction structs, result kind codes and character codes.
// No dependencies.
package htp_pkg;

    localparam int LENGTH_WIDTH_DEF = 16;
    localparam int SIZE_WIDTH_DEF   = 20;

    typedef struct packed {
        logic       mode;
        logic [7:0] ch;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] value;
        logic        status;
        logic [19:0] hdr_size;
    } t_out_item;

    localparam logic [2:0] KIND_LITERAL = 3'd0;
    localparam logic [2:0] KIND_COUNTER = 3'd1;
    localparam logic [2:0] KIND_STAMP   = 3'd2;
    localparam logic [2:0] KIND_RBYTES  = 3'd3;
    localparam logic [2:0] KIND_RALNUM  = 3'd4;
    localparam logic [2:0] KIND_RDIGIT  = 3'd5;
    localparam logic [2:0] KIND_END     = 3'd6;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LC    = 8'h63;
    localparam logic [7:0] CH_LD    = 8'h64;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LR    = 8'h72;
    localparam logic [7:0] CH_LT_T  = 8'h74;
    localparam logic [7:0] CH_LX    = 8'h78;

endpackage

// File: design/header_template_tag_parser_unit.sv
// Header template tag parser, top level.
// Depends on htp_pkg for the transaction structs, kind codes and character codes.
//
// The parser takes one template character (or an end marker) per cycle and gives at most one
// result in the cycle after the character is accepted; a single result register separates the
// two channels, so a new character is taken in every cycle unless that register is full and
// stalled. Literal bytes from <b HEX> fields, counter/timestamp records and random tag records
// stream out as they are recognized; an end transaction reports status and total size and
// returns the parser to its reset state. When the end reports status 1, the receiver must
// discard every result given since the previous end.
module header_template_tag_parser_unit #(
    parameter int LENGTH_WIDTH = htp_pkg::LENGTH_WIDTH_DEF,
    parameter int SIZE_WIDTH   = htp_pkg::SIZE_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  htp_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output htp_pkg::t_out_item o_out_data
);

    localparam int LW    = LENGTH_WIDTH;
    localparam int SW    = SIZE_WIDTH;
    localparam int SUM_W = ((LW > SW) ? LW : SW) + 1;

    typedef enum logic [10:0] {
        PH_IDLE   = 11'b00000000001,
        PH_OPEN   = 11'b00000000010,
        PH_B1     = 11'b00000000100,
        PH_CT     = 11'b00000001000,
        PH_R1     = 11'b00000010000,
        PH_R2     = 11'b00000100000,
        PH_HEX    = 11'b00001000000,
        PH_LSTART = 11'b00010000000,
        PH_LWS    = 11'b00100000000,
        PH_LSIGN  = 11'b01000000000,
        PH_LDIG   = 11'b10000000000
    } t_phase;

    function automatic logic is_ws6(input logic [7:0] c);
        return (c == htp_pkg::CH_SPACE) || (c == htp_pkg::CH_TAB) || (c == htp_pkg::CH_NL)
            || (c == htp_pkg::CH_VT) || (c == htp_pkg::CH_FF) || (c == htp_pkg::CH_CR);
    endfunction

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= htp_pkg::CH_ZERO) && (c <= htp_pkg::CH_NINE);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_dec(c) || ((c >= htp_pkg::CH_LA) && (c <= htp_pkg::CH_LF))
            || ((c >= htp_pkg::CH_UA) && (c <= htp_pkg::CH_UF));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (is_dec(c)) begin
            v = 4'(c - htp_pkg::CH_ZERO);
        end else if ((c >= htp_pkg::CH_LA) && (c <= htp_pkg::CH_LF)) begin
            v = 4'(c - htp_pkg::CH_LA + 8'd10);
        end else if ((c >= htp_pkg::CH_UA) && (c <= htp_pkg::CH_UF)) begin
            v = 4'(c - htp_pkg::CH_UA + 8'd10);
        end
        return v;
    endfunction

    // Decode one hex pair the way strtol base 16 treats a two-character string.
    function automatic logic [7:0] decode_pair(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] hb;
        logic [7:0] res;
        hb  = is_hex(b) ? {4'd0, hex_val(b)} : 8'd0;
        res = 8'd0;
        if (is_ws6(a) || (a == htp_pkg::CH_PLUS)) begin
            res = hb;
        end else if (a == htp_pkg::CH_MINUS) begin
            res = 8'd0 - hb;
        end else if (is_hex(a)) begin
            if ((a == htp_pkg::CH_ZERO) && ((b == htp_pkg::CH_LX) || (b == htp_pkg::CH_UX))) begin
                res = 8'd0;
            end else if (is_hex(b)) begin
                res = {hex_val(a), hex_val(b)};
            end else begin
                res = {4'd0, hex_val(a)};
            end
        end
        return res;
    endfunction

    t_phase              r_phase, n_phase;
    logic [7:0]          r_held, n_held;
    logic [1:0]          r_hex_cnt, n_hex_cnt;
    logic                r_hex_seen, n_hex_seen;
    logic [2:0]          r_pend_kind, n_pend_kind;
    logic [LW-1:0]       r_len, n_len;
    logic [SW-1:0]       r_size, n_size;
    logic                r_cnt_seen, n_cnt_seen;
    logic                r_stamp_seen, n_stamp_seen;
    logic                r_err, n_err;
    logic                r_out_valid;
    htp_pkg::t_out_item  r_out_data;

    logic                in_accept;
    logic                n_emit;
    htp_pkg::t_out_item  n_item;
    logic [7:0]          ch;
    logic [LW-1:0]       grow_n;
    logic [SUM_W-1:0]    grow_sum;
    logic                grow_ok;
    logic [LW+3:0]       len_prod;
    logic                len_over;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_accept   = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign ch          = i_in_data.ch;

    // One adder serves all size growth: 8 for counter/timestamp, the length for random tags,
    // one for a literal byte.
    always_comb begin
        if (r_phase == PH_CT) begin
            grow_n = LW'(8);
        end else if ((r_phase == PH_LSTART) || (r_phase == PH_LDIG)) begin
            grow_n = r_len;
        end else begin
            grow_n = LW'(1);
        end
    end

    assign grow_sum = SUM_W'(r_size) + SUM_W'(grow_n);
    assign grow_ok  = (grow_sum[SUM_W-1:SW] == '0);

    assign len_prod = {1'b0, r_len, 3'b000} + {3'b000, r_len, 1'b0}
                    + (LW+4)'(4'(ch - htp_pkg::CH_ZERO));
    assign len_over = (len_prod[LW+3:LW] != '0);

    always_comb begin
        n_phase      = r_phase;
        n_held       = r_held;
        n_hex_cnt    = r_hex_cnt;
        n_hex_seen   = r_hex_seen;
        n_pend_kind  = r_pend_kind;
        n_len        = r_len;
        n_size       = r_size;
        n_cnt_seen   = r_cnt_seen;
        n_stamp_seen = r_stamp_seen;
        n_err        = r_err;
        n_emit       = 1'b0;
        n_item       = '0;

        if (in_accept) begin
            if (i_in_data.mode) begin
                n_emit          = 1'b1;
                n_item.kind     = htp_pkg::KIND_END;
                n_item.status   = r_err || (r_phase != PH_IDLE);
                n_item.hdr_size = n_item.status ? 20'd0 : 20'(r_size);
                n_phase      = PH_IDLE;
                n_held       = 8'd0;
                n_hex_cnt    = 2'd0;
                n_hex_seen   = 1'b0;
                n_pend_kind  = 3'd0;
                n_len        = '0;
                n_size       = '0;
                n_cnt_seen   = 1'b0;
                n_stamp_seen = 1'b0;
                n_err        = 1'b0;
            end else if (!r_err) begin
                unique case (r_phase)
                    PH_IDLE: begin
                        if (ch == htp_pkg::CH_LT) begin
                            n_phase = PH_OPEN;
                        end else if ((ch != htp_pkg::CH_SPACE) && (ch != htp_pkg::CH_TAB)
                                     && (ch != htp_pkg::CH_NL)) begin
                            n_err = 1'b1;
                        end
                    end
                    PH_OPEN: begin
                        priority if (ch == htp_pkg::CH_LB) begin
                            n_phase = PH_B1;
                        end else if (ch == htp_pkg::CH_LC) begin
                            n_phase     = PH_CT;
                            n_pend_kind = htp_pkg::KIND_COUNTER;
                        end else if (ch == htp_pkg::CH_LT_T) begin
                            n_phase     = PH_CT;
                            n_pend_kind = htp_pkg::KIND_STAMP;
                        end else if (ch == htp_pkg::CH_LR) begin
                            n_phase = PH_R1;
                        end else begin
                            n_err   = 1'b1;
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_B1: begin
                        if (ch == htp_pkg::CH_SPACE) begin
                            n_phase    = PH_HEX;
                            n_hex_cnt  = 2'd0;
                            n_hex_seen = 1'b0;
                        end else begin
                            n_err   = 1'b1;
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_CT: begin
                        n_phase = PH_IDLE;
                        if ((ch != htp_pkg::CH_GT)
                            || ((r_pend_kind == htp_pkg::KIND_COUNTER) && r_cnt_seen)
                            || ((r_pend_kind != htp_pkg::KIND_COUNTER) && r_stamp_seen)) begin
                            n_err = 1'b1;
                        end else begin
                            if (r_pend_kind == htp_pkg::KIND_COUNTER) begin
                                n_cnt_seen = 1'b1;
                            end else begin
                                n_stamp_seen = 1'b1;
                            end
                            if (grow_ok) begin
                                n_size      = grow_sum[SW-1:0];
                                n_emit      = 1'b1;
                                n_item.kind = r_pend_kind;
                            end else begin
                                n_err = 1'b1;
                            end
                        end
                    end
                    PH_R1: begin
                        n_len = '0;
                        priority if (ch == htp_pkg::CH_SPACE) begin
                            n_phase     = PH_LSTART;
                            n_pend_kind = htp_pkg::KIND_RBYTES;
                        end else if (ch == htp_pkg::CH_LC) begin
                            n_phase     = PH_R2;
                            n_pend_kind = htp_pkg::KIND_RALNUM;
                        end else if (ch == htp_pkg::CH_LD) begin
                            n_phase     = PH_R2;
                            n_pend_kind = htp_pkg::KIND_RDIGIT;
                        end else begin
                            n_err   = 1'b1;
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_R2: begin
                        n_len = '0;
                        if (ch == htp_pkg::CH_SPACE) begin
                            n_phase = PH_LSTART;
                        end else begin
                            n_err   = 1'b1;
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_HEX: begin
                        if (ch == htp_pkg::CH_GT) begin
                            n_phase = PH_IDLE;
                            if (!((r_hex_cnt == 2'd2) && r_hex_seen)) begin
                                n_err = 1'b1;
                            end
                        end else if ((r_hex_cnt == 2'd0) || (r_hex_cnt == 2'd2)) begin
                            // hold the first character of a pair
                            n_held    = ch;
                            n_hex_cnt = r_hex_cnt + 2'd1;
                        end else begin
                            n_hex_cnt = 2'd2;
                            // drop a leading 0x prefix
                            if (!((r_hex_cnt == 2'd1) && (r_held == htp_pkg::CH_ZERO)
                                  && ((ch == htp_pkg::CH_LX) || (ch == htp_pkg::CH_UX)))) begin
                                n_hex_seen = 1'b1;
                                if (grow_ok) begin
                                    n_size       = grow_sum[SW-1:0];
                                    n_emit       = 1'b1;
                                    n_item.kind  = htp_pkg::KIND_LITERAL;
                                    n_item.value = {8'd0, decode_pair(r_held, ch)};
                                end else begin
                                    n_err   = 1'b1;
                                    n_phase = PH_IDLE;
                                end
                            end
                        end
                    end
                    PH_LSTART, PH_LWS, PH_LSIGN, PH_LDIG: begin
                        priority if (is_dec(ch)) begin
                            if (len_over) begin
                                n_err   = 1'b1;
                                n_phase = PH_IDLE;
                            end else begin
                                n_len   = len_prod[LW-1:0];
                                n_phase = PH_LDIG;
                            end
                        end else if ((ch == htp_pkg::CH_GT)
                                     && ((r_phase == PH_LSTART) || (r_phase == PH_LDIG))) begin
                            n_phase = PH_IDLE;
                            if (grow_ok) begin
                                n_size       = grow_sum[SW-1:0];
                                n_emit       = 1'b1;
                                n_item.kind  = r_pend_kind;
                                n_item.value = 16'(r_len);
                            end else begin
                                n_err = 1'b1;
                            end
                        end else if (is_ws6(ch)
                                     && ((r_phase == PH_LSTART) || (r_phase == PH_LWS))) begin
                            n_phase = PH_LWS;
                        end else if ((ch == htp_pkg::CH_PLUS)
                                     && ((r_phase == PH_LSTART) || (r_phase == PH_LWS))) begin
                            n_phase = PH_LSIGN;
                        end else begin
                            n_err   = 1'b1;
                            n_phase = PH_IDLE;
                        end
                    end
                    default: begin
                        n_err   = 1'b1;
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_held       <= 8'd0;
            r_hex_cnt    <= 2'd0;
            r_hex_seen   <= 1'b0;
            r_pend_kind  <= 3'd0;
            r_len        <= '0;
            r_size       <= '0;
            r_cnt_seen   <= 1'b0;
            r_stamp_seen <= 1'b0;
            r_err        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_held       <= n_held;
            r_hex_cnt    <= n_hex_cnt;
            r_hex_seen   <= n_hex_seen;
            r_pend_kind  <= n_pend_kind;
            r_len        <= n_len;
            r_size       <= n_size;
            r_cnt_seen   <= n_cnt_seen;
            r_stamp_seen <= n_stamp_seen;
            r_err        <= n_err;
            if (in_accept) begin
                r_out_valid <= n_emit;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && n_emit) begin
            r_out_data <= n_item;
        end
    end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for header_template_tag_parser_unit.
// Drives template strings and end markers, predicts each result in a tag-parser model of its
// own and checks every output transaction. Depends on htp_pkg and the parser RTL.
module testbench;
    import htp_pkg::*;

    localparam int SIZE_MAX     = (1 << SIZE_WIDTH_DEF) - 1;
    localparam int LEN_MAX      = (1 << LENGTH_WIDTH_DEF) - 1;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 300;
    localparam int LATENCY_TAIL = 20;
    localparam int N_DIR        = 28;
    // in directed text this character stands for a zero byte
    localparam logic [7:0] ZERO_MARK = 8'h7E;

    typedef enum logic [3:0] {
        PH_IDLE, PH_OPEN, PH_B1, PH_CT, PH_R1, PH_R2, PH_HEX,
        PH_LSTART, PH_LWS, PH_LSIGN, PH_LDIG
    } t_parse_phase;

    typedef struct packed {
        logic        typed;
        logic        status;
        logic [19:0] total;
    } t_end_check;

    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    t_in_item   i_in_data   = '0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_item  o_out_data;
    t_end_check end_check   = '0;

    t_out_item pending_results[$];
    int mismatches = 0;
    int live_chars = 0;
    int cycle_cnt  = 0;
    int send_pct   = 0;
    int recv_pct   = 0;
    int hold_req   = 0;
    int hold_seen  = 0;
    int hold_left  = 0;

    // parser state as predicted
    t_parse_phase tp_phase;
    logic [7:0]   tp_held;
    int           tp_hex_cnt;
    bit           tp_hex_seen;
    logic [2:0]   tp_kind;
    int           tp_len;
    int           tp_size;
    bit           tp_counter_seen;
    bit           tp_stamp_seen;
    bit           tp_err;

    string dir_text [N_DIR] = '{
        "",
        " \t\n<c>",
        "<t>\n<c> ",
        "<c><c>",
        "<t>\t<t>",
        "<b 0x0aFf>",
        "<b 0X>",
        "<b >",
        "<b 123>",
        "<b  1+2-3\t40xzz\0131\0145\0156>",
        "<b ~1~~>",
        "<b 00fF\377A>",
        "<r 65535>",
        "<r 65536>",
        "<rc ><rc 5><rd 6>",
        "<rd \t+0012>",
        "<r \013\014\015 7>",
        "<r  >",
        "<r +>",
        "<r -5>",
        "<x>",
        "a<c>",
        "<c",
        "<b 12",
        "<c x>",
        "<bx>",
        "",
        ""
    };
    // -1: end result comes from the prediction alone
    int dir_status [N_DIR] = '{0, 0, 0, 1, 1, 0, 1, 1, 1, -1, -1, 0, 0, 1,
                               0, 0, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 1};
    int dir_total  [N_DIR] = '{0, 8, 16, 0, 0, 2, 0, 0, 0, 0, 0, 3, 65535, 0,
                               11, 12, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1048575, 0};

    header_template_tag_parser_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("testbench: done, errors");
        $finish;
    end

    function automatic bit is_ws6(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_VT ||
               c == CH_FF || c == CH_CR;
    endfunction

    function automatic int hex_val(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
        if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
        if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
        return -1;
    endfunction

    // one byte of a hex field, with the C library's lenient conversion rules
    function automatic logic [7:0] decode_pair(input logic [7:0] a, input logic [7:0] b);
        int ha;
        int hb;
        ha = hex_val(a);
        hb = hex_val(b);
        if (hb < 0 && (is_ws6(a) || a == CH_PLUS || a == CH_MINUS)) hb = 0;
        if (is_ws6(a) || a == CH_PLUS) return 8'(hb);
        if (a == CH_MINUS) return 8'(256 - hb);
        if (ha >= 0) begin
            if (a == CH_ZERO && (b == CH_LX || b == CH_UX)) return 8'h00;
            if (hb >= 0) return 8'(ha * 16 + hb);
            return 8'(ha);
        end
        return 8'h00;
    endfunction

    function automatic void clear_parser();
        tp_phase        = PH_IDLE;
        tp_held         = '0;
        tp_hex_cnt      = 0;
        tp_hex_seen     = 1'b0;
        tp_kind         = KIND_LITERAL;
        tp_len          = 0;
        tp_size         = 0;
        tp_counter_seen = 1'b0;
        tp_stamp_seen   = 1'b0;
        tp_err          = 1'b0;
    endfunction

    function automatic void latch_error();
        tp_err   = 1'b1;
        tp_phase = PH_IDLE;
    endfunction

    function automatic bit add_size(input int n);
        if (tp_size + n > SIZE_MAX) begin
            latch_error();
            return 1'b0;
        end
        tp_size += n;
        return 1'b1;
    endfunction

    // Advance the predicted parser by one transaction; return 1 when it yields a result.
    function automatic bit parse_char(input t_in_item it, output t_out_item res);
        logic [7:0] c;
        bit got;
        bit pair_done;
        c         = it.ch;
        res       = '0;
        got       = 1'b0;
        pair_done = 1'b0;
        if (it.mode) begin
            res.kind     = KIND_END;
            res.status   = tp_err || tp_phase != PH_IDLE;
            res.hdr_size = res.status ? 20'd0 : 20'(tp_size);
            clear_parser();
            return 1'b1;
        end
        if (tp_err) return 1'b0;
        case (tp_phase)
            PH_IDLE: begin
                if (c == CH_LT) tp_phase = PH_OPEN;
                else if (!(c == CH_SPACE || c == CH_TAB || c == CH_NL)) latch_error();
            end
            PH_OPEN: begin
                if (c == CH_LB) tp_phase = PH_B1;
                else if (c == CH_LC) begin
                    tp_phase = PH_CT;
                    tp_kind  = KIND_COUNTER;
                end else if (c == CH_LT_T) begin
                    tp_phase = PH_CT;
                    tp_kind  = KIND_STAMP;
                end else if (c == CH_LR) tp_phase = PH_R1;
                else latch_error();
            end
            PH_B1: begin
                if (c == CH_SPACE) begin
                    tp_phase    = PH_HEX;
                    tp_hex_cnt  = 0;
                    tp_hex_seen = 1'b0;
                end else latch_error();
            end
            PH_CT: begin
                if (c != CH_GT) latch_error();
                else if (tp_kind == KIND_COUNTER && tp_counter_seen) latch_error();
                else if (tp_kind == KIND_STAMP && tp_stamp_seen) latch_error();
                else begin
                    if (tp_kind == KIND_COUNTER) tp_counter_seen = 1'b1;
                    else tp_stamp_seen = 1'b1;
                    tp_phase = PH_IDLE;
                    if (add_size(8)) begin
                        res.kind = tp_kind;
                        got      = 1'b1;
                    end
                end
            end
            PH_R1: begin
                tp_len = 0;
                if (c == CH_SPACE) begin
                    tp_phase = PH_LSTART;
                    tp_kind  = KIND_RBYTES;
                end else if (c == CH_LC) begin
                    tp_phase = PH_R2;
                    tp_kind  = KIND_RALNUM;
                end else if (c == CH_LD) begin
                    tp_phase = PH_R2;
                    tp_kind  = KIND_RDIGIT;
                end else latch_error();
            end
            PH_R2: begin
                tp_len = 0;
                if (c == CH_SPACE) tp_phase = PH_LSTART;
                else latch_error();
            end
            PH_HEX: begin
                if (c == CH_GT) begin
                    if (tp_hex_cnt == 2 && tp_hex_seen) tp_phase = PH_IDLE;
                    else latch_error();
                end else begin
                    case (tp_hex_cnt)
                        0: begin
                            tp_held    = c;
                            tp_hex_cnt = 1;
                        end
                        1: begin
                            tp_hex_cnt = 2;
                            // drop a leading 0x prefix
                            pair_done = !(tp_held == CH_ZERO && (c == CH_LX || c == CH_UX));
                        end
                        2: begin
                            tp_held    = c;
                            tp_hex_cnt = 3;
                        end
                        default: begin
                            tp_hex_cnt = 2;
                            pair_done  = 1'b1;
                        end
                    endcase
                end
            end
            default: begin
                if (c >= CH_ZERO && c <= CH_NINE) begin
                    tp_len = tp_len * 10 + int'(c - CH_ZERO);
                    if (tp_len > LEN_MAX) latch_error();
                    else tp_phase = PH_LDIG;
                end else if (c == CH_GT && (tp_phase == PH_LSTART || tp_phase == PH_LDIG)) begin
                    tp_phase = PH_IDLE;
                    if (add_size(tp_len)) begin
                        res.kind  = tp_kind;
                        res.value = 16'(tp_len);
                        got       = 1'b1;
                    end
                end else if (is_ws6(c) && (tp_phase == PH_LSTART || tp_phase == PH_LWS)) begin
                    tp_phase = PH_LWS;
                end else if (c == CH_PLUS && (tp_phase == PH_LSTART || tp_phase == PH_LWS)) begin
                    tp_phase = PH_LSIGN;
                end else latch_error();
            end
        endcase
        if (pair_done) begin
            tp_hex_seen = 1'b1;
            if (add_size(1)) begin
                res.kind  = KIND_LITERAL;
                res.value = {8'h00, decode_pair(tp_held, c)};
                got       = 1'b1;
            end
        end
        return got;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // Check output transactions, then predict from the input transaction of the same edge.
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        t_out_item got;
        t_out_item pred;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got = o_out_data;
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result with none expected: kind %0d value %0d",
                                              got.kind, got.value));
                end else begin
                    want = pending_results.pop_front();
                    if (got.kind !== want.kind)
                        report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
                    if (got.value !== want.value)
                        report_mismatch($sformatf("value %0d, want %0d (kind %0d)",
                                                  got.value, want.value, want.kind));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  got.status, want.status));
                    if (got.hdr_size !== want.hdr_size)
                        report_mismatch($sformatf("hdr_size %0d, want %0d",
                                                  got.hdr_size, want.hdr_size));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                if (!tp_err && !i_in_data.mode) live_chars++;
                if (parse_char(i_in_data, pred)) begin
                    if (pred.kind == KIND_END && end_check.typed) begin
                        pred.status   = end_check.status;
                        pred.hdr_size = end_check.total;
                    end
                    pending_results.push_back(pred);
                end
            end
        end
    end

    // receiver: random stall, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left   = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_pct);
        end
    end

    task automatic send_item(input t_in_item it, input t_end_check chk);
        while ($urandom_range(99) < send_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        end_check  <= chk;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_template(ref logic [7:0] q[$], input t_end_check chk);
        foreach (q[i]) send_item({1'b0, q[i]}, '0);
        send_item({1'b1, 8'($urandom_range(255))}, chk);
    endtask

    // hold the sender until every expected result is in
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic void push_text(ref logic [7:0] q[$], input string s);
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    endfunction

    function automatic logic [7:0] pick_gap();
        case ($urandom_range(2))
            0: return CH_SPACE;
            1: return CH_TAB;
            default: return CH_NL;
        endcase
    endfunction

    function automatic logic [7:0] pick_ws6();
        case ($urandom_range(5))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_NL;
            3: return CH_VT;
            4: return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] pick_hex_char();
        int r;
        logic [7:0] c;
        r = $urandom_range(99);
        if (r < 30) return CH_ZERO + 8'($urandom_range(9));
        if (r < 50) return CH_LA + 8'($urandom_range(5));
        if (r < 70) return CH_UA + 8'($urandom_range(5));
        case ($urandom_range(5))
            0: return pick_ws6();
            1: return CH_PLUS;
            2: return CH_MINUS;
            3: return $urandom_range(1) ? CH_LX : CH_UX;
            default: begin
                do c = 8'($urandom_range(255)); while (c == CH_GT);
                return c;
            end
        endcase
    endfunction

    // Mostly well-formed templates with random content; some noise and broken tags.
    function automatic void build_template(ref logic [7:0] q[$]);
        int r;
        int n;
        int v;
        bit have_c;
        bit have_t;
        q      = {};
        have_c = 1'b0;
        have_t = 1'b0;
        repeat ($urandom_range(1, 5)) begin
            repeat ($urandom_range(0, 2)) q.push_back(pick_gap());
            r = $urandom_range(99);
            if (r < 35) begin
                push_text(q, "<b ");
                if ($urandom_range(3) == 0) push_text(q, $urandom_range(1) ? "0x" : "0X");
                n = 2 * $urandom_range(1, 4);
                // odd or empty field now and then
                if ($urandom_range(19) == 0) n = $urandom_range(0, 3);
                repeat (n) q.push_back(pick_hex_char());
                q.push_back(CH_GT);
            end else if (r < 45 && (!have_c || $urandom_range(9) == 0)) begin
                push_text(q, "<c>");
                have_c = 1'b1;
            end else if (r < 55 && (!have_t || $urandom_range(9) == 0)) begin
                push_text(q, "<t>");
                have_t = 1'b1;
            end else if (r < 88) begin
                push_text(q, "<r");
                case ($urandom_range(2))
                    1: q.push_back(CH_LC);
                    2: q.push_back(CH_LD);
                    default: ;
                endcase
                q.push_back(CH_SPACE);
                r = $urandom_range(99);
                if (r >= 4) begin
                    if ($urandom_range(7) == 0) q.push_back(pick_ws6());
                    if ($urandom_range(7) == 0) q.push_back(CH_PLUS);
                    else if ($urandom_range(29) == 0) q.push_back(CH_MINUS);
                    if ($urandom_range(9) == 0) q.push_back(CH_ZERO);
                    if (r < 70) v = $urandom_range(200);
                    else if (r < 92) v = $urandom_range(65535);
                    else if (r < 96) v = 65535;
                    else v = 65536 + $urandom_range(99999);
                    push_text(q, $sformatf("%0d", v));
                end
                q.push_back(CH_GT);
            end else begin
                case ($urandom_range(3))
                    0: q.push_back(8'($urandom_range(255)));
                    1: begin
                        q.push_back(CH_LT);
                        q.push_back(8'($urandom_range(255)));
                        q.push_back(CH_GT);
                    end
                    2: begin
                        push_text(q, "<b");
                        q.push_back(8'($urandom_range(255)));
                    end
                    default: begin
                        push_text(q, "<r");
                        q.push_back(8'($urandom_range(255)));
                    end
                endcase
            end
        end
        // end inside an open tag now and then
        if ($urandom_range(24) == 0) push_text(q, $urandom_range(1) ? "<c" : "<r 1");
    endfunction

    initial begin : main_seq
        logic [7:0] tmpl[$];
        string s;
        logic [7:0] c;
        t_end_check chk;
        int target;
        clear_parser();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // size bound: the first template lands exactly on it, the second goes one byte over
        s = "";
        repeat (16) s = {s, "<r 65535>"};
        dir_text[N_DIR-2] = {s, "<c><b 01020304050607>"};
        dir_text[N_DIR-1] = {s, "<r 16>"};

        send_pct = 20;
        recv_pct = 20;
        for (int r = 0; r < N_DIR; r++) begin
            s    = dir_text[r];
            tmpl = {};
            for (int i = 0; i < s.len(); i++) begin
                c = s[i];
                tmpl.push_back(c == ZERO_MARK ? 8'h00 : c);
            end
            chk = '0;
            if (dir_status[r] >= 0) begin
                chk.typed  = 1'b1;
                chk.status = dir_status[r] != 0;
                chk.total  = 20'(dir_total[r]);
            end
            send_template(tmpl, chk);
        end

        for (int ph = 0; ph < 3; ph++) begin
            wait_results_drained();
            send_pct = (ph == 0) ? 32 : (ph == 1) ? 62 : 0;
            recv_pct = (ph == 0) ? 62 : (ph == 1) ? 32 : 0;
            // hold the receiver off while the sender keeps offering
            if (ph == 1) hold_req++;
            target = live_chars + 30;
            while (live_chars < target) begin
                build_template(tmpl);
                send_template(tmpl, '0);
            end
        end

        wait_results_drained();
        repeat (LATENCY_TAIL) @(posedge i_clk);
        if (mismatches == 0) $display("testbench: done, clean");
        else $display("testbench: done, errors");
        $finish;
    end

endmodule
